### hdl/tfmf_pkg.sv
// tfmf_pkg: shared types, constants and coefficient rom for the magic formula tire core
// no dependencies; imported by every module of the block

package tfmf_pkg;

	// pipeline geometry
	localparam int ATAN_STEPS = 16;
	localparam int SQRT_STEPS = 17;
	localparam int MS_LAT     = 53;
	localparam int STG_SINE   = 1 + MS_LAT;
	localparam int STG_PROD   = STG_SINE + 1;
	localparam int STG_RAD    = STG_PROD + 1;
	localparam int STG_ROOT   = STG_RAD + SQRT_STEPS;
	localparam int STG_FYP    = STG_ROOT + 1;
	localparam int PIPE_DEPTH = STG_FYP + 1;

	// datapath widths
	localparam int COEF_W = 18;
	localparam int ARG_W  = 17;
	localparam int BK_W   = 37;
	localparam int LIN_W  = 44;
	localparam int AT_W   = 48;
	localparam int Z_W    = 20;
	localparam int ANG_W  = 24;
	localparam int SN_W   = 34;
	localparam int SIN_W  = 32;
	localparam int RAD_W  = 34;
	localparam int ROOT_W = 18;
	localparam int REM_W  = 22;

	localparam logic signed [SN_W-1:0]  GAIN_INV_Q30 = 34'sd652032874;
	localparam logic signed [SN_W-1:0]  ONE_Q30      = 34'sd1073741824;
	localparam logic signed [ANG_W-1:0] PI_Q16       = 24'sd205887;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q16  = 24'sd102944;

	localparam logic signed [Z_W-1:0] ATAN_TAB [0:ATAN_STEPS-1] = '{
		20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
		20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
		20'sd8, 20'sd4, 20'sd2
	};

	// surface codes and register indexes
	localparam logic [1:0] SURF_DRY  = 2'd0;
	localparam logic [1:0] SURF_WET  = 2'd1;
	localparam logic [1:0] SURF_SNOW = 2'd2;
	localparam logic CFG_SURFACE = 1'b0;
	localparam logic CFG_EPSILON = 1'b1;

	typedef struct packed {
		logic [15:0] lat_slip;
		logic [15:0] long_slip;
		logic [15:0] normal_load;
		logic        axle_select;
	} tfmf_in_t;

	typedef struct packed {
		logic [23:0] force_long;
		logic [23:0] force_lat;
	} tfmf_out_t;

	// coefficients in q.12
	typedef struct packed {
		logic [COEF_W-1:0] mu_x;
		logic [COEF_W-1:0] mu_y;
		logic [COEF_W-1:0] bx;
		logic [COEF_W-1:0] by;
		logic [COEF_W-1:0] cx;
		logic [COEF_W-1:0] cy;
		logic [COEF_W-1:0] ex;
		logic [COEF_W-1:0] ey;
	} coef_t;

	function automatic coef_t mk_coef(input int a, input int b, input int c, input int d,
			input int e, input int f, input int g, input int h);
		coef_t r;
		r.mu_x = COEF_W'(a);
		r.mu_y = COEF_W'(b);
		r.bx   = COEF_W'(c);
		r.by   = COEF_W'(d);
		r.cx   = COEF_W'(e);
		r.cy   = COEF_W'(f);
		r.ex   = COEF_W'(g);
		r.ey   = COEF_W'(h);
		return r;
	endfunction

	// unused surface code falls back to dry asphalt
	function automatic coef_t coef_rom(input logic [1:0] surf, input logic axle);
		coef_t r;
		unique case (surf)
			SURF_WET: begin
				r = axle ? mk_coef(4383, 3731, 47104, 46285, 7373, 4383, 1229, -8069)
					: mk_coef(4342, 3625, 49152, 43827, 7373, 4383, 1282, -8765);
			end
			SURF_SNOW: begin
				r = axle ? mk_coef(1675, 1614, 39772, 81920, 8028, 2253, 2556, -7905)
					: mk_coef(1667, 1569, 41779, 78234, 8028, 2253, 2666, -8602);
			end
			default: begin
				r = axle ? mk_coef(4915, 3936, 45466, 38093, 6922, 4874, 1483, -4547)
					: mk_coef(4915, 3830, 47923, 36291, 6922, 4874, 1544, -4956);
			end
		endcase
		return r;
	endfunction

endpackage

### hdl/tire_force_magic_formula_core.sv
// tire_force_magic_formula_core: top level of the magic formula tire force pipeline
// depends on tfmf_pkg, tfmf_magic_sine and tfmf_isqrt

// One input word (slip angle, slip ratio, normal load, axle) gives one result word
// (longitudinal and coupled lateral force, 1/16 N). The datapath is a fixed pipeline of
// PIPE_DEPTH (75) register stages: a coefficient lookup, two parallel magic formula sine
// units of 53 stages each (three 16-step cordic pipelines), force products, and a
// 17-stage square root for the friction ellipse coupling. A new word is taken in every
// clock cycle unless the pipeline is held. The whole pipeline advances together; it
// holds only while the output register is full and not taken. Configuration (surface
// set, coupling epsilon) is written through the plain write port and should only change
// while the pipeline is empty.

module tire_force_magic_formula_core import tfmf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  tfmf_in_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output tfmf_out_t result,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic [15:0] cfg_wdata
);

	// configuration registers
	logic [1:0]  surface_q;
	logic [15:0] eps_q;

	// pipeline valid bits, one per stage
	logic [PIPE_DEPTH:1] vld_q;
	logic en;

	// stage 1: coefficients and operands
	coef_t                    coef_s1;
	logic signed [ARG_W-1:0]  alpha_s1;
	logic signed [ARG_W-1:0]  kappa_s1;
	logic [15:0]              fz_s1;

	// mu*fz carried to the sine outputs
	logic signed [31:0] px_c, py_c;
	logic signed [31:0] px_d [2:STG_PROD];
	logic signed [31:0] py_d [2:STG_SINE];

	logic signed [SIN_W-1:0] sx, sy;

	// force products and radicand
	logic signed [61:0] fxp_c, typ_c;
	logic signed [63:0] sq_c;
	logic signed [61:0] fxp_s55, typ_s55;
	logic [32:0]        s2_s55;
	logic signed [61:0] fxr;
	logic signed [23:0] fx_d [STG_RAD:STG_FYP];
	logic signed [43:0] t_d [STG_RAD:STG_ROOT];
	logic [RAD_W-1:0]   rad_s56;
	logic [ROOT_W-1:0]  root;
	logic signed [62:0] fyp_c, fyp_s74, fyr;
	tfmf_out_t          res_s75;

	// ---- configuration port ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			surface_q <= SURF_DRY;
			eps_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SURFACE: surface_q <= cfg_wdata[1:0];
				CFG_EPSILON: eps_q     <= cfg_wdata;
				default:     ;
			endcase
		end
	end

	// ---- flow control: whole pipeline moves unless the result word is held ----
	assign en           = !vld_q[PIPE_DEPTH] || result_ready;
	assign item_ready   = en;
	assign result_valid = vld_q[PIPE_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-1:1], item_valid};
		end
	end

	// ---- stage 1: rom lookup, slip ratio brought to q.14 ----
	always_ff @(posedge clk) begin
		if (en) begin
			coef_s1  <= coef_rom(surface_q, item.axle_select);
			alpha_s1 <= ARG_W'($signed(item.lat_slip));
			kappa_s1 <= $signed({item.long_slip, 1'b0});
			fz_s1    <= item.normal_load;
		end
	end

	// ---- stage 2: peak force scale mu*fz ----
	assign px_c = $signed(coef_s1.mu_x) * $signed({1'b0, fz_s1});
	assign py_c = $signed(coef_s1.mu_y) * $signed({1'b0, fz_s1});

	always_ff @(posedge clk) begin
		if (en) begin
			px_d[2] <= px_c;
			py_d[2] <= py_c;
		end
	end

	genvar j;
	for (j = 3; j <= STG_PROD; j++) begin : g_pxd
		always_ff @(posedge clk) begin
			if (en) px_d[j] <= px_d[j-1];
		end
	end
	for (j = 3; j <= STG_SINE; j++) begin : g_pyd
		always_ff @(posedge clk) begin
			if (en) py_d[j] <= py_d[j-1];
		end
	end

	// ---- magic formula sine terms, longitudinal and lateral side by side ----
	tfmf_magic_sine u_sine_x (
		.clk  (clk),
		.en   (en),
		.b    ($signed(coef_s1.bx)),
		.c    ($signed(coef_s1.cx)),
		.e    ($signed(coef_s1.ex)),
		.arg  (kappa_s1),
		.sine (sx)
	);

	tfmf_magic_sine u_sine_y (
		.clk  (clk),
		.en   (en),
		.b    ($signed(coef_s1.by)),
		.c    ($signed(coef_s1.cy)),
		.e    ($signed(coef_s1.ey)),
		.arg  (alpha_s1),
		.sine (sy)
	);

	// ---- stage 55: force products and sine squared ----
	assign fxp_c = px_d[STG_SINE] * sx;
	assign typ_c = py_d[STG_SINE] * sy;
	assign sq_c  = sx * sx;

	always_ff @(posedge clk) begin
		if (en) begin
			fxp_s55 <= fxp_c;
			typ_s55 <= typ_c;
			s2_s55  <= sq_c[60:28];
		end
	end

	// ---- stage 56: rounded longitudinal force, lateral partial, coupling radicand ----
	assign fxr = fxp_s55 + 62'sd137438953472;

	always_ff @(posedge clk) begin
		if (en) begin
			fx_d[STG_RAD] <= fxr[61:38];
			t_d[STG_RAD]  <= typ_s55[61:18];
			rad_s56       <= 34'h1_0000_0000 - {1'b0, s2_s55} + {2'b00, eps_q, 16'h0000};
		end
	end

	for (j = STG_RAD + 1; j <= STG_FYP; j++) begin : g_fxd
		always_ff @(posedge clk) begin
			if (en) fx_d[j] <= fx_d[j-1];
		end
	end
	for (j = STG_RAD + 1; j <= STG_ROOT; j++) begin : g_td
		always_ff @(posedge clk) begin
			if (en) t_d[j] <= t_d[j-1];
		end
	end

	// ---- stages 57 to 73: friction ellipse root ----
	tfmf_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (rad_s56),
		.root (root)
	);

	// ---- stage 74: coupled lateral product ----
	assign fyp_c = t_d[STG_ROOT] * $signed({1'b0, root});

	always_ff @(posedge clk) begin
		if (en) fyp_s74 <= fyp_c;
	end

	// ---- stage 75: output word ----
	assign fyr = fyp_s74 + 63'sd34359738368;

	always_ff @(posedge clk) begin
		if (en) begin
			res_s75.force_long <= fx_d[STG_FYP];
			res_s75.force_lat  <= fyr[59:36];
		end
	end

	assign result = res_s75;

`ifndef ASSERT_OFF
	// a held pipeline keeps every stage's occupancy
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline occupancy changed during stall");

	// sine outputs stay inside the unit range
	a_sine_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[STG_SINE] |-> (sx <= 32'sd1073741824) && (sx >= -32'sd1073741824)
			&& (sy <= 32'sd1073741824) && (sy >= -32'sd1073741824))
		else $error("sine term out of range");

	// zero load gives zero longitudinal product
	a_zero_load: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[STG_PROD] && (px_d[STG_PROD] == 32'sd0) |-> (fxp_s55 == 62'sd0))
		else $error("longitudinal force nonzero at zero load");
`endif

endmodule

### hdl/tfmf_magic_sine.sv
// tfmf_magic_sine: pipelined sin(c*atan(b*(1-e)*x + e*atan(b*x))) in q.30
// depends on tfmf_pkg; three chained cordic pipelines of ATAN_STEPS stages

module tfmf_magic_sine import tfmf_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [COEF_W-1:0] b,
	input  logic signed [COEF_W-1:0] c,
	input  logic signed [COEF_W-1:0] e,
	input  logic signed [ARG_W-1:0]  arg,
	output logic signed [SIN_W-1:0]  sine
);

	logic signed [BK_W-1:0]   bk_s1;
	logic signed [COEF_W-1:0] c_d [1:34];
	logic signed [COEF_W-1:0] e_d [1:17];
	logic signed [LIN_W-1:0]  lin_d [2:17];
	logic signed [18:0]       one_me;
	logic signed [55:0]       lin_prod;
	logic signed [37:0]       bend_p;
	logic signed [AT_W-1:0]   ang_s18;
	logic signed [37:0]       cp_s35;
	logic signed [ANG_W-1:0]  a_raw;
	logic signed [ANG_W-1:0]  z0_s36;
	logic signed [SIN_W-1:0]  sine_s53;

	logic signed [AT_W-1:0] x1_in [0:ATAN_STEPS-1], y1_in [0:ATAN_STEPS-1];
	logic signed [Z_W-1:0]  z1_in [0:ATAN_STEPS-1];
	logic signed [AT_W-1:0] x1_s [0:ATAN_STEPS-1], y1_s [0:ATAN_STEPS-1];
	logic signed [Z_W-1:0]  z1_s [0:ATAN_STEPS-1];
	logic signed [AT_W-1:0] x2_in [0:ATAN_STEPS-1], y2_in [0:ATAN_STEPS-1];
	logic signed [Z_W-1:0]  z2_in [0:ATAN_STEPS-1];
	logic signed [AT_W-1:0] x2_s [0:ATAN_STEPS-1], y2_s [0:ATAN_STEPS-1];
	logic signed [Z_W-1:0]  z2_s [0:ATAN_STEPS-1];
	logic signed [SN_W-1:0]  x3_in [0:ATAN_STEPS-1], y3_in [0:ATAN_STEPS-1];
	logic signed [ANG_W-1:0] z3_in [0:ATAN_STEPS-1];
	logic signed [SN_W-1:0]  x3_s [0:ATAN_STEPS-1], y3_s [0:ATAN_STEPS-1];
	logic signed [ANG_W-1:0] z3_s [0:ATAN_STEPS-1];

	// b*arg, q.26
	always_ff @(posedge clk) begin
		if (en) begin
			bk_s1  <= b * arg;
			c_d[1] <= c;
			e_d[1] <= e;
		end
	end

	genvar j;
	for (j = 2; j <= 34; j++) begin : g_cdel
		always_ff @(posedge clk) begin
			if (en) c_d[j] <= c_d[j-1];
		end
	end
	for (j = 2; j <= 17; j++) begin : g_edel
		always_ff @(posedge clk) begin
			if (en) e_d[j] <= e_d[j-1];
		end
	end

	// linear part (1-e)*b*x
	assign one_me   = 19'sd4096 - 19'(e_d[1]);
	assign lin_prod = one_me * bk_s1;

	always_ff @(posedge clk) begin
		if (en) lin_d[2] <= lin_prod[55:12];
	end
	for (j = 3; j <= 17; j++) begin : g_ldel
		always_ff @(posedge clk) begin
			if (en) lin_d[j] <= lin_d[j-1];
		end
	end

	// first arctangent, vectoring mode
	genvar i;
	for (i = 0; i < ATAN_STEPS; i++) begin : g_at1
		if (i == 0) begin : g_first
			assign x1_in[i] = 48'sd67108864;
			assign y1_in[i] = AT_W'(bk_s1);
			assign z1_in[i] = '0;
		end else begin : g_next
			assign x1_in[i] = x1_s[i-1];
			assign y1_in[i] = y1_s[i-1];
			assign z1_in[i] = z1_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!y1_in[i][AT_W-1]) begin
					x1_s[i] <= x1_in[i] + (y1_in[i] >>> i);
					y1_s[i] <= y1_in[i] - (x1_in[i] >>> i);
					z1_s[i] <= z1_in[i] + ATAN_TAB[i];
				end else begin
					x1_s[i] <= x1_in[i] - (y1_in[i] >>> i);
					y1_s[i] <= y1_in[i] + (x1_in[i] >>> i);
					z1_s[i] <= z1_in[i] - ATAN_TAB[i];
				end
			end
		end
	end

	// bend term e*atan(b*x) joins the linear part
	assign bend_p = e_d[17] * z1_s[ATAN_STEPS-1];

	always_ff @(posedge clk) begin
		if (en) ang_s18 <= AT_W'(lin_d[17]) + AT_W'(bend_p >>> 2);
	end

	// second arctangent
	for (i = 0; i < ATAN_STEPS; i++) begin : g_at2
		if (i == 0) begin : g_first
			assign x2_in[i] = 48'sd67108864;
			assign y2_in[i] = ang_s18;
			assign z2_in[i] = '0;
		end else begin : g_next
			assign x2_in[i] = x2_s[i-1];
			assign y2_in[i] = y2_s[i-1];
			assign z2_in[i] = z2_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!y2_in[i][AT_W-1]) begin
					x2_s[i] <= x2_in[i] + (y2_in[i] >>> i);
					y2_s[i] <= y2_in[i] - (x2_in[i] >>> i);
					z2_s[i] <= z2_in[i] + ATAN_TAB[i];
				end else begin
					x2_s[i] <= x2_in[i] - (y2_in[i] >>> i);
					y2_s[i] <= y2_in[i] + (x2_in[i] >>> i);
					z2_s[i] <= z2_in[i] - ATAN_TAB[i];
				end
			end
		end
	end

	// shape factor, then fold into one half turn
	always_ff @(posedge clk) begin
		if (en) cp_s35 <= c_d[34] * z2_s[ATAN_STEPS-1];
	end

	assign a_raw = cp_s35[35:12];

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (a_raw > HALF_PI_Q16) z0_s36 <= PI_Q16 - a_raw;
			else if (a_raw < -HALF_PI_Q16) z0_s36 <= -PI_Q16 - a_raw;
			else z0_s36 <= a_raw;
		end
	end

	// sine, rotation mode
	for (i = 0; i < ATAN_STEPS; i++) begin : g_sin
		if (i == 0) begin : g_first
			assign x3_in[i] = GAIN_INV_Q30;
			assign y3_in[i] = '0;
			assign z3_in[i] = z0_s36;
		end else begin : g_next
			assign x3_in[i] = x3_s[i-1];
			assign y3_in[i] = y3_s[i-1];
			assign z3_in[i] = z3_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z3_in[i][ANG_W-1]) begin
					x3_s[i] <= x3_in[i] - (y3_in[i] >>> i);
					y3_s[i] <= y3_in[i] + (x3_in[i] >>> i);
					z3_s[i] <= z3_in[i] - ANG_W'(ATAN_TAB[i]);
				end else begin
					x3_s[i] <= x3_in[i] + (y3_in[i] >>> i);
					y3_s[i] <= y3_in[i] - (x3_in[i] >>> i);
					z3_s[i] <= z3_in[i] + ANG_W'(ATAN_TAB[i]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (y3_s[ATAN_STEPS-1] > ONE_Q30) sine_s53 <= SIN_W'(ONE_Q30);
			else if (y3_s[ATAN_STEPS-1] < -ONE_Q30) sine_s53 <= SIN_W'(-ONE_Q30);
			else sine_s53 <= y3_s[ATAN_STEPS-1][SIN_W-1:0];
		end
	end

	assign sine = sine_s53;

endmodule

### hdl/tfmf_isqrt.sv
// tfmf_isqrt: pipelined integer square root, one result bit per stage
// depends on tfmf_pkg

module tfmf_isqrt import tfmf_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [RAD_W-1:0]  rad,
	output logic [ROOT_W-1:0] root
);

	logic [RAD_W-1:0]  v_in [0:SQRT_STEPS-1], v_s [0:SQRT_STEPS-1];
	logic [REM_W-1:0]  rem_in [0:SQRT_STEPS-1], rem_s [0:SQRT_STEPS-1];
	logic [ROOT_W-1:0] rt_in [0:SQRT_STEPS-1], rt_s [0:SQRT_STEPS-1];
	logic [REM_W-1:0]  r2 [0:SQRT_STEPS-1];
	logic [REM_W-1:0]  trial [0:SQRT_STEPS-1];

	genvar i;
	for (i = 0; i < SQRT_STEPS; i++) begin : g_st
		if (i == 0) begin : g_first
			assign v_in[i]   = rad;
			assign rem_in[i] = '0;
			assign rt_in[i]  = '0;
		end else begin : g_next
			assign v_in[i]   = v_s[i-1];
			assign rem_in[i] = rem_s[i-1];
			assign rt_in[i]  = rt_s[i-1];
		end
		// bring down the next bit pair
		assign r2[i]    = {rem_in[i][REM_W-3:0], v_in[i][RAD_W-1-2*i -: 2]};
		assign trial[i] = {2'b00, rt_in[i], 2'b01};
		always_ff @(posedge clk) begin
			if (en) begin
				v_s[i] <= v_in[i];
				if (r2[i] >= trial[i]) begin
					rem_s[i] <= r2[i] - trial[i];
					rt_s[i]  <= {rt_in[i][ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[i] <= r2[i];
					rt_s[i]  <= {rt_in[i][ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign root = rt_s[SQRT_STEPS-1];

endmodule
